>>> hw/rtl/xcfp_pkg.sv
package xcfp_pkg;

   // Frame delimiter and the power-up value of the inter-byte timeout.
   localparam logic [7:0]  HEADER_BYTE   = 8'hAA;
   localparam logic [15:0] TIMEOUT_RESET = 16'd50;

   // One received byte and the tick count at its arrival.
   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [31:0] tick_now;
   } req_type;

   // One result: frame flag and the latched command bytes.
   typedef struct packed {
      logic       frame_valid;
      logic [7:0] speed_cmd;
      logic [7:0] turn_cmd;
      logic [7:0] heading_cmd;
   } rsp_type;

endpackage

>>> hw/rtl/xcfp_in_stage.sv
module xcfp_in_stage
   import xcfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   input  logic    advance,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   // The stage takes a new byte when it is empty or its content moves on.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_valid ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/xcfp_parse.sv
module xcfp_parse
   import xcfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     item,
   input  logic [15:0] timeout_ticks,
   output rsp_type     result
);

   typedef enum logic [2:0] {
      PH_HEAD    = 3'd0,
      PH_SPEED   = 3'd1,
      PH_TURN    = 3'd2,
      PH_HEADING = 3'd3,
      PH_CHECK   = 3'd4,
      PH_TAIL    = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  speed_ff, speed_in;
   logic [7:0]  turn_ff, turn_in;
   logic [7:0]  heading_ff, heading_in;
   logic [7:0]  acc_speed_ff, acc_speed_in;
   logic [7:0]  acc_turn_ff, acc_turn_in;
   logic [7:0]  acc_heading_ff, acc_heading_in;
   logic [31:0] last_tick_ff;
   logic [31:0] gap;
   logic        timed_out;
   logic        match;

   // Gap wraps modulo 2^32; only an open frame can time out.
   assign gap       = item.tick_now - last_tick_ff;
   assign timed_out = (phase_ff != PH_HEAD) && (gap > {16'd0, timeout_ticks});
   assign cur_phase = timed_out ? PH_HEAD : phase_ff;

   always_comb begin
      phase_in       = cur_phase;
      xor_in         = xor_ff;
      speed_in       = speed_ff;
      turn_in        = turn_ff;
      heading_in     = heading_ff;
      acc_speed_in   = acc_speed_ff;
      acc_turn_in    = acc_turn_ff;
      acc_heading_in = acc_heading_ff;
      match          = 1'b0;
      unique case (cur_phase)
         PH_HEAD: begin
            if (item.rx_byte == HEADER_BYTE) begin
               phase_in = PH_SPEED;
               xor_in   = 8'd0;
            end
         end
         PH_SPEED: begin
            speed_in = item.rx_byte;
            xor_in   = xor_ff ^ item.rx_byte;
            phase_in = PH_TURN;
         end
         PH_TURN: begin
            turn_in  = item.rx_byte;
            xor_in   = xor_ff ^ item.rx_byte;
            phase_in = PH_HEADING;
         end
         PH_HEADING: begin
            heading_in = item.rx_byte;
            xor_in     = xor_ff ^ item.rx_byte;
            phase_in   = PH_CHECK;
         end
         PH_CHECK: begin
            if (item.rx_byte == xor_ff) begin
               match          = 1'b1;
               phase_in       = PH_TAIL;
               acc_speed_in   = speed_ff;
               acc_turn_in    = turn_ff;
               acc_heading_in = heading_ff;
            end else begin
               phase_in = PH_HEAD;
            end
         end
         default: begin
            // The tail byte is consumed whatever its value.
            phase_in = PH_HEAD;
         end
      endcase
   end

   assign result.frame_valid = match;
   assign result.speed_cmd   = acc_speed_in;
   assign result.turn_cmd    = acc_turn_in;
   assign result.heading_cmd = acc_heading_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEAD;
         xor_ff         <= 8'd0;
         speed_ff       <= 8'd0;
         turn_ff        <= 8'd0;
         heading_ff     <= 8'd0;
         acc_speed_ff   <= 8'd0;
         acc_turn_ff    <= 8'd0;
         acc_heading_ff <= 8'd0;
         last_tick_ff   <= 32'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         xor_ff         <= xor_in;
         speed_ff       <= speed_in;
         turn_ff        <= turn_in;
         heading_ff     <= heading_in;
         acc_speed_ff   <= acc_speed_in;
         acc_turn_ff    <= acc_turn_in;
         acc_heading_ff <= acc_heading_in;
         last_tick_ff   <= item.tick_now;
      end
   end

endmodule

>>> hw/rtl/xor_checked_command_frame_parser_core.sv
// Command frame parser with an XOR check. Each request transfer carries one received
// byte and the tick count at which it arrived; each one produces exactly one response
// transfer. A frame is six bytes: 0xAA, speed, turn rate, heading, the XOR of those
// three, and a tail byte that is ignored. When the check byte matches, the response
// has frame_valid set and carries the new command bytes; otherwise the command fields
// repeat the last good frame (zero after reset). If more than csr_wr_data ticks
// (register timeout_ff, reset value 50) pass between two bytes of an open frame,
// the frame is dropped and the late byte is examined as a possible header. The block
// takes one byte per clock as long as the response side keeps taking transfers: a
// byte is registered at the input, the parser state and the response are computed
// from it combinationally, and the response sits in an output register. Write the
// timeout only while the block is idle.
module xor_checked_command_frame_parser_core
   import xcfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0] timeout_ff;
   logic        item_valid;
   req_type     item;
   logic        advance;
   rsp_type     result;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_payload_ff;

   // The registered byte moves on whenever the output register is empty or is
   // being drained in this same cycle.
   assign advance = item_valid && (!rsp_valid_ff || rsp_ready);

   xcfp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   // The parser state only changes when a byte is actually handed to the output.
   xcfp_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .item          (item),
      .timeout_ticks (timeout_ff),
      .result        (result)
   );

   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> hw/rtl/xcfp_checker.sv
module xcfp_checker
   import xcfp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   logic rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // Nothing is offered on the response side right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // A good check byte is always followed by a tail byte, so two back-to-back
   // response transfers can never both flag a frame.
   a_no_double_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_payload.frame_valid |=> !(rsp_xfer && rsp_payload.frame_valid))
      else $error("two frames on consecutive transfers");

   // Without a new frame the command bytes repeat those of the previous transfer.
   a_cmd_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |=> !(rsp_xfer && !rsp_payload.frame_valid)
         || (rsp_payload.speed_cmd == $past(rsp_payload.speed_cmd)
            && rsp_payload.turn_cmd == $past(rsp_payload.turn_cmd)
            && rsp_payload.heading_cmd == $past(rsp_payload.heading_cmd)))
      else $error("command bytes changed without a frame");

   // A byte offered while the input side is ready is taken; the input side is ready
   // after reset.
   a_ready_after_reset: assert property (@(posedge clock) reset |=> req_ready || !req_valid)
      else $error("input not ready after reset");

endmodule

bind xor_checked_command_frame_parser_core xcfp_checker u_xcfp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

>>> tb/sv/testbench.sv
module testbench;
   import xcfp_pkg::*;

   // Cycles with no transfer on either channel before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 1000;
   // Length of the deliberate response-side hold-off that fills the block.
   localparam int LONG_HOLD = 120;
   localparam int MAX_PRINTED = 40;

   // Parser phases as the predictor tracks them.
   typedef enum logic [2:0] {
      HUNT,
      GET_SPEED,
      GET_TURN,
      GET_HEADING,
      GET_CHECK,
      SKIP_TAIL
   } parse_state_type;

   // One row of the directed sequence. When known is set, the response is
   // typed in here; otherwise it comes from the predictor.
   typedef struct packed {
      logic [7:0]  rx;
      logic [31:0] tick;
      logic        known;
      rsp_type     want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // Predictor state: a private copy of the parser and its timeout register.
   parse_state_type pstate = HUNT;
   logic [7:0]   xor_sum = '0;
   logic [7:0]   part_speed = '0;
   logic [7:0]   part_turn = '0;
   logic [7:0]   part_heading = '0;
   logic [7:0]   cmd_speed = '0;
   logic [7:0]   cmd_turn = '0;
   logic [7:0]   cmd_heading = '0;
   logic [31:0]  prev_tick = '0;
   logic [15:0]  gap_limit = TIMEOUT_RESET;

   // Responses still owed by the block, oldest first.
   rsp_type      expected_frames[$];
   int           mismatch_count = 0;
   int           bytes_sent = 0;
   int           responses_seen = 0;
   int           idle_cycles = 0;
   logic [31:0]  tick_cursor = '0;

   // Directed sequence. It covers the reset state, a good frame with extreme
   // payload values, a tail byte that looks like a header, a bad check byte,
   // a gap exactly at the timeout, a gap one past it that lands on a header,
   // and a good frame whose ticks wrap around zero.
   directed_row_type directed_plan [0:20] = '{
      '{8'h00, 32'd0,          1'b1, {1'b0, 8'h00, 8'h00, 8'h00}},
      '{8'hAA, 32'd1,          1'b0, '0},
      '{8'h00, 32'd2,          1'b0, '0},
      '{8'hFF, 32'd3,          1'b0, '0},
      '{8'h80, 32'd4,          1'b0, '0},
      '{8'h7F, 32'd5,          1'b1, {1'b1, 8'h00, 8'hFF, 8'h80}},
      '{8'hAA, 32'd6,          1'b1, {1'b0, 8'h00, 8'hFF, 8'h80}},
      '{8'hAA, 32'd7,          1'b0, '0},
      '{8'h12, 32'd8,          1'b0, '0},
      '{8'h34, 32'd9,          1'b0, '0},
      '{8'h56, 32'd10,         1'b0, '0},
      '{8'h00, 32'd11,         1'b1, {1'b0, 8'h00, 8'hFF, 8'h80}},
      '{8'hAA, 32'd12,         1'b0, '0},
      '{8'h11, 32'd62,         1'b0, '0},
      '{8'hAA, 32'd113,        1'b0, '0},
      '{8'hAA, 32'hFFFF_FFF0,  1'b0, '0},
      '{8'h01, 32'h0000_0010,  1'b0, '0},
      '{8'h02, 32'h0000_0020,  1'b0, '0},
      '{8'h04, 32'h0000_0030,  1'b0, '0},
      '{8'h07, 32'h0000_0040,  1'b1, {1'b1, 8'h01, 8'h02, 8'h04}},
      '{8'h55, 32'h0000_0041,  1'b0, '0}
   };

   xor_checked_command_frame_parser_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string text);
      if (mismatch_count < MAX_PRINTED) begin
         $display("mismatch: %s", text);
      end
      mismatch_count++;
   endtask

   // Advances the parser copy by one byte and returns the response it owes.
   // An open frame whose gap exceeds the timeout falls back to hunting first,
   // so the late byte is still looked at as a header.
   function automatic rsp_type parse_byte(input req_type item);
      rsp_type result;
      result.frame_valid = 1'b0;
      if (pstate != HUNT && (item.tick_now - prev_tick) > 32'(gap_limit)) begin
         pstate = HUNT;
      end
      prev_tick = item.tick_now;
      case (pstate)
         HUNT: begin
            if (item.rx_byte == HEADER_BYTE) begin
               pstate = GET_SPEED;
               xor_sum = '0;
            end
         end
         GET_SPEED: begin
            part_speed = item.rx_byte;
            xor_sum = xor_sum ^ item.rx_byte;
            pstate = GET_TURN;
         end
         GET_TURN: begin
            part_turn = item.rx_byte;
            xor_sum = xor_sum ^ item.rx_byte;
            pstate = GET_HEADING;
         end
         GET_HEADING: begin
            part_heading = item.rx_byte;
            xor_sum = xor_sum ^ item.rx_byte;
            pstate = GET_CHECK;
         end
         GET_CHECK: begin
            // A bad check byte drops the frame but keeps the last good commands.
            if (item.rx_byte == xor_sum) begin
               pstate = SKIP_TAIL;
               cmd_speed = part_speed;
               cmd_turn = part_turn;
               cmd_heading = part_heading;
               result.frame_valid = 1'b1;
            end else begin
               pstate = HUNT;
            end
         end
         default: begin
            // The tail byte ends the frame whatever its value.
            pstate = HUNT;
         end
      endcase
      result.speed_cmd = cmd_speed;
      result.turn_cmd = cmd_turn;
      result.heading_cmd = cmd_heading;
      return result;
   endfunction

   // Picks the tick of the next byte. Most gaps stay within the timeout, some
   // sit exactly on it or one past it, and a few jump anywhere in the 32-bit
   // range so that every tick bit toggles and wraparound is exercised.
   function automatic logic [31:0] advance_tick();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         tick_cursor = $urandom();
      end else if (pick < 8) begin
         tick_cursor = tick_cursor + 32'(gap_limit) + 32'd1;
      end else if (pick < 12) begin
         tick_cursor = tick_cursor + 32'(gap_limit);
      end else begin
         tick_cursor = tick_cursor + 32'($urandom_range(0, gap_limit));
      end
      return tick_cursor;
   endfunction

   // Offers one byte and returns at the edge where the transfer happens. The
   // expectation is queued in that same step so the response side never sees
   // the queue lag behind the block. Valid stays high into the next call when
   // that call draws no gap, so it is never lowered and raised in one step.
   task automatic offer(input logic [7:0] rx, input logic [31:0] tick,
                        input logic known, input rsp_type want);
      req_type item;
      rsp_type predicted;
      int      gap;
      item.rx_byte = rx;
      item.tick_now = tick;
      // Every 80 bytes the first 20 go back to back.
      gap = (bytes_sent % 80 < 20) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predicted = parse_byte(item);
      expected_frames.push_back(known ? want : predicted);
      bytes_sent++;
   endtask

   // The timeout register may only change while the block is empty, so the
   // sender stops and waits for every owed response before writing it.
   task automatic set_timeout(input logic [15:0] value);
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      gap_limit = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly well-formed frames with random payloads. About one check byte in
   // eight is corrupted, one frame in ten is cut short, a quarter of the tail
   // bytes look like headers, and short bursts of noise fall between frames.
   task automatic run_frames(input int frames_wanted);
      logic [7:0] body [0:5];
      int         cut;
      int         k;
      int         n;
      for (n = 0; n < frames_wanted; n++) begin
         body[0] = HEADER_BYTE;
         body[1] = 8'($urandom());
         body[2] = 8'($urandom());
         body[3] = 8'($urandom());
         body[4] = body[1] ^ body[2] ^ body[3];
         if ($urandom_range(0, 7) == 0) begin
            body[4] = body[4] ^ 8'($urandom_range(1, 255));
         end
         body[5] = ($urandom_range(0, 3) == 0) ? HEADER_BYTE : 8'($urandom());
         cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 6;
         for (k = 0; k < cut; k++) begin
            offer(body[k], advance_tick(), 1'b0, '0);
         end
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) offer(8'($urandom()), advance_tick(), 1'b0, '0);
         end
      end
   endtask

   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (expected_frames.size() == 0) begin
         report_mismatch($sformatf("response %0d arrived with nothing pending",
                                   responses_seen));
         return;
      end
      want = expected_frames.pop_front();
      if (got.frame_valid !== want.frame_valid) begin
         report_mismatch($sformatf("response %0d frame_valid got %b want %b",
                                   responses_seen, got.frame_valid, want.frame_valid));
      end
      if (got.speed_cmd !== want.speed_cmd) begin
         report_mismatch($sformatf("response %0d speed_cmd got %h want %h",
                                   responses_seen, got.speed_cmd, want.speed_cmd));
      end
      if (got.turn_cmd !== want.turn_cmd) begin
         report_mismatch($sformatf("response %0d turn_cmd got %h want %h",
                                   responses_seen, got.turn_cmd, want.turn_cmd));
      end
      if (got.heading_cmd !== want.heading_cmd) begin
         report_mismatch($sformatf("response %0d heading_cmd got %h want %h",
                                   responses_seen, got.heading_cmd, want.heading_cmd));
      end
   endtask

   // Response side. It stalls a random number of cycles before each transfer,
   // runs without stalls for stretches, and twice holds off for a long time
   // while the sender keeps offering bytes, so the block fills and blocks its
   // input.
   initial begin : response_sink
      int stall;
      forever begin
         if (responses_seen == 200 || responses_seen == 470) begin
            stall = LONG_HOLD;
         end else if (responses_seen % 90 < 25) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 6);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (reset || rsp_valid !== 1'b1) @(posedge clock);
         check_response(rsp_payload);
         responses_seen++;
      end
   end

   // Any transfer on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : byte_source
      int row;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part runs with the power-up timeout.
      for (row = 0; row < 21; row++) begin
         offer(directed_plan[row].rx, directed_plan[row].tick,
               directed_plan[row].known, directed_plan[row].want);
      end
      tick_cursor = directed_plan[20].tick;

      // Random part, one phase per timeout setting, extremes included.
      set_timeout(16'd0);
      run_frames(21);
      set_timeout(16'hFFFF);
      run_frames(21);
      set_timeout(16'($urandom_range(2, 65534)));
      run_frames(21);
      set_timeout(16'd1);
      run_frames(21);
      set_timeout(TIMEOUT_RESET);
      run_frames(21);

      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      // Give a stray extra response time to show up.
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/xcfp_pkg.sv
hw/rtl/xcfp_in_stage.sv
hw/rtl/xcfp_parse.sv
hw/rtl/xor_checked_command_frame_parser_core.sv
hw/rtl/xcfp_checker.sv
tb/sv/testbench.sv
